// File: rtl/assert_macros.svh
// Assertion macros used by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RMET_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmet assertion failed");
`define RMET_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rmet assertion failed");
`else
`define RMET_ASSERT(lbl, clk, rst_n, prop)
`define RMET_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/rmet_pkg.sv
// Types and constants of the relative mouse event translator.
package rmet_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         event_code;
    logic signed [15:0] event_value;
  } rmet_in_t;

  typedef struct packed {
    logic [3:0]         action_kind;
    logic [23:0]        cursor_x;
    logic [23:0]        cursor_y;
    logic signed [11:0] scroll_amount;
  } rmet_out_t;

  typedef enum logic [3:0] {
    ACT_MOVE         = 4'd0,
    ACT_DRAG_LEFT    = 4'd1,
    ACT_DRAG_RIGHT   = 4'd2,
    ACT_DRAG_OTHER   = 4'd3,
    ACT_LEFT_DOWN    = 4'd4,
    ACT_LEFT_UP      = 4'd5,
    ACT_RIGHT_DOWN   = 4'd6,
    ACT_RIGHT_UP     = 4'd7,
    ACT_OTHER_DOWN   = 4'd8,
    ACT_OTHER_UP     = 4'd9,
    ACT_SCROLL       = 4'd10
  } rmet_action_e;

  typedef enum logic [1:0] {
    CFG_DISPLAY_WIDTH    = 2'd0,
    CFG_DISPLAY_HEIGHT   = 2'd1,
    CFG_SPEED_MULTIPLIER = 2'd2
  } rmet_cfg_e;

  localparam logic [1:0]  TYPE_BUTTON = 2'd1;
  localparam logic [1:0]  TYPE_AXIS   = 2'd2;
  localparam logic [9:0]  CODE_X      = 10'd0;
  localparam logic [9:0]  CODE_Y      = 10'd1;
  localparam logic [9:0]  CODE_SCROLL = 10'd11;
  localparam logic [9:0]  BTN_LEFT    = 10'd272;
  localparam logic [9:0]  BTN_RIGHT   = 10'd273;
  localparam logic [9:0]  BTN_MIDDLE  = 10'd274;

  localparam logic signed [15:0] VAL_PRESSED = 16'sd1;
  localparam logic signed [15:0] VAL_HELD    = 16'sd2;

  localparam logic [15:0] WIDTH_RESET  = 16'd1920;
  localparam logic [15:0] HEIGHT_RESET = 16'd1080;
  localparam logic [15:0] GAIN_RESET   = 16'd256;

  // Reciprocal of the scroll divisor, 20 fractional bits: ceil(2^20 / 20)
  localparam int          SCROLL_SHIFT = 20;
  localparam logic [15:0] SCROLL_RECIP = 16'd52429;

endpackage

// File: rtl/relative_mouse_event_translator_top.sv
// Top level of the relative mouse event translator.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+--------------------------
//  in      | sink      | valid / stall    | rmet_in_t  (type, code, value)
//  out     | source    | valid / stall    | rmet_out_t (kind, x, y, scroll)
//  cfg     | sink      | valid / ready    | 2-bit index, 16-bit data
//
// One beat per cycle while the output is not stalled: an event is
// captured in the input register, the multiply, add and clamp run
// while it sits there, and the result lands in the output register
// when the event advances.
// Reset clears the cursor to the origin, forgets the last button and
// restores the display size and gain. Output stall holds the result
// register; the input register then holds too, and in_stall_o rises only
// while both are full and the output is stalled. The config port is always
// ready.
`include "assert_macros.svh"

module relative_mouse_event_translator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmet_pkg::rmet_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rmet_pkg::rmet_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  // Configuration registers
  logic [15:0] width_q, height_q, gain_q;

  // Input register
  logic               in_valid_q;
  rmet_pkg::rmet_in_t in_data_q;

  // Cursor state
  logic [23:0] pos_x_q, pos_y_q;
  logic [23:0] pos_x_d, pos_y_d;
  rmet_pkg::rmet_action_e last_btn_q, last_btn_d;

  // Result register
  logic                out_valid_q;
  rmet_pkg::rmet_out_t out_data_q, out_data_d;

  logic advance;
  logic emit;
  logic btn_hit;

  assign cfg_ready_o = 1'b1;

  // Advance the held event when the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rmet_pkg::WIDTH_RESET;
      height_q <= rmet_pkg::HEIGHT_RESET;
      gain_q   <= rmet_pkg::GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rmet_pkg::CFG_DISPLAY_WIDTH:    width_q  <= cfg_data_i;
        rmet_pkg::CFG_DISPLAY_HEIGHT:   height_q <= cfg_data_i;
        rmet_pkg::CFG_SPEED_MULTIPLIER: gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Datapath: one axis goes through the scaler, the other is only clamped
  logic        sel_y;
  logic [23:0] axis_base, axis_new;
  logic [15:0] axis_limit;
  logic [23:0] hi_x, hi_y, clamp_x, clamp_y;
  logic signed [11:0] scroll_step;

  assign sel_y      = (in_data_q.event_code == rmet_pkg::CODE_Y);
  assign axis_base  = sel_y ? pos_y_q : pos_x_q;
  assign axis_limit = sel_y ? height_q : width_q;
  assign hi_x       = {width_q, 8'h00};
  assign hi_y       = {height_q, 8'h00};
  assign clamp_x    = (pos_x_q > hi_x) ? hi_x : pos_x_q;
  assign clamp_y    = (pos_y_q > hi_y) ? hi_y : pos_y_q;

  rmet_pos_unit u_pos (
    .pos_i   (axis_base),
    .limit_i (axis_limit),
    .value_i (in_data_q.event_value),
    .gain_i  (gain_q),
    .pos_o   (axis_new)
  );

  rmet_scroll_div u_scroll (
    .value_i (in_data_q.event_value),
    .step_o  (scroll_step)
  );

  rmet_pkg::rmet_action_e drag_kind;
  rmet_pkg::rmet_action_e btn_act;
  logic                   btn_known;

  always_comb begin
    case (last_btn_q)
      rmet_pkg::ACT_LEFT_DOWN:  drag_kind = rmet_pkg::ACT_DRAG_LEFT;
      rmet_pkg::ACT_RIGHT_DOWN: drag_kind = rmet_pkg::ACT_DRAG_RIGHT;
      rmet_pkg::ACT_OTHER_DOWN: drag_kind = rmet_pkg::ACT_DRAG_OTHER;
      default:                  drag_kind = rmet_pkg::ACT_MOVE;
    endcase
  end

  always_comb begin
    logic pressed;
    pressed   = (in_data_q.event_value == rmet_pkg::VAL_PRESSED);
    btn_known = 1'b1;
    case (in_data_q.event_code)
      rmet_pkg::BTN_LEFT:
        btn_act = pressed ? rmet_pkg::ACT_LEFT_DOWN : rmet_pkg::ACT_LEFT_UP;
      rmet_pkg::BTN_RIGHT:
        btn_act = pressed ? rmet_pkg::ACT_RIGHT_DOWN : rmet_pkg::ACT_RIGHT_UP;
      rmet_pkg::BTN_MIDDLE:
        btn_act = pressed ? rmet_pkg::ACT_OTHER_DOWN : rmet_pkg::ACT_OTHER_UP;
      default: begin
        btn_act   = rmet_pkg::ACT_MOVE;
        btn_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic is_axis, is_btn, is_move, is_scroll;
    is_axis   = (in_data_q.req_type == rmet_pkg::TYPE_AXIS);
    is_btn    = (in_data_q.req_type == rmet_pkg::TYPE_BUTTON);
    is_move   = is_axis && (in_data_q.event_code == rmet_pkg::CODE_X || sel_y);
    is_scroll = is_axis && (in_data_q.event_code == rmet_pkg::CODE_SCROLL);
    // Held buttons and unknown codes drop silently
    btn_hit   = is_btn && btn_known && (in_data_q.event_value != rmet_pkg::VAL_HELD);
    emit      = is_move || is_scroll || btn_hit;

    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    last_btn_d = last_btn_q;

    out_data_d.action_kind   = 4'(drag_kind);
    out_data_d.cursor_x      = pos_x_q;
    out_data_d.cursor_y      = pos_y_q;
    out_data_d.scroll_amount = '0;

    if (is_move) begin
      pos_x_d = sel_y ? clamp_x : axis_new;
      pos_y_d = sel_y ? axis_new : clamp_y;
      out_data_d.cursor_x = pos_x_d;
      out_data_d.cursor_y = pos_y_d;
    end else if (is_scroll) begin
      out_data_d.action_kind   = 4'(rmet_pkg::ACT_SCROLL);
      out_data_d.scroll_amount = scroll_step;
    end else if (btn_hit) begin
      last_btn_d             = btn_act;
      out_data_d.action_kind = 4'(btn_act);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      last_btn_q <= rmet_pkg::ACT_MOVE;
    end else if (advance) begin
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      last_btn_q <= last_btn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Short names for the conditions checked below
  logic res_not_scroll, move_taken, res_in_range;
  assign res_not_scroll = out_valid_q && (out_data_q.action_kind != 4'(rmet_pkg::ACT_SCROLL));
  assign move_taken     = advance && emit &&
                          (out_data_d.action_kind <= 4'(rmet_pkg::ACT_DRAG_OTHER));
  assign res_in_range   = (out_data_q.cursor_x <= hi_x) && (out_data_q.cursor_y <= hi_y);

  // Stall only while both registers are full
  `RMET_ASSERT(a_stall_full, clk_i, rst_ni, in_stall_o |-> in_valid_q && out_valid_q)
  // Only a scroll result carries a scroll step
  `RMET_ASSERT(a_scroll_zero, clk_i, rst_ni, res_not_scroll |-> out_data_q.scroll_amount == 12'sd0)
  // A button result is remembered for later drags
  `RMET_ASSERT(a_btn_kept, clk_i, rst_ni, (advance && btn_hit) |=> 4'(last_btn_q) == out_data_q.action_kind)
  // A move or drag never leaves the cursor past the display edge
  `RMET_ASSERT(a_clamped, clk_i, rst_ni, move_taken |=> res_in_range)

endmodule

// File: rtl/rmet_pos_unit.sv
// Scaled relative motion added to one coordinate, then clamped.
module rmet_pos_unit (
  input  logic [23:0]        pos_i,
  input  logic [15:0]        limit_i,
  input  logic signed [15:0] value_i,
  input  logic [15:0]        gain_i,
  output logic [23:0]        pos_o
);

  logic signed [32:0] delta;
  logic signed [33:0] sum;
  logic [23:0]        hi;

  assign delta = value_i * $signed({1'b0, gain_i});
  assign sum   = $signed({10'b0, pos_i}) + {delta[32], delta};
  assign hi    = {limit_i, 8'h00};

  always_comb begin
    if (sum < 34'sd0) begin
      pos_o = '0;
    end else if (sum > $signed({10'b0, hi})) begin
      pos_o = hi;
    end else begin
      pos_o = sum[23:0];
    end
  end

endmodule

// File: rtl/rmet_scroll_div.sv
// Scroll value divided by the scroll divisor, truncated toward zero.
module rmet_scroll_div (
  input  logic signed [15:0] value_i,
  output logic signed [11:0] step_o
);

  logic        neg;
  logic [15:0] mag;
  logic [31:0] prod;
  logic [11:0] quo;

  assign neg  = value_i[15];
  // Magnitude fits 16 unsigned bits, even for the most negative value
  assign mag  = neg ? 16'(-value_i) : value_i;
  assign prod = mag * rmet_pkg::SCROLL_RECIP;
  assign quo  = prod[rmet_pkg::SCROLL_SHIFT +: 12];
  assign step_o = neg ? $signed(-quo) : $signed(quo);

endmodule
